>>> sv/bgmd_pkg.sv
// Package for the BLDC gate mode decoder: drive mode and level codes,
// six-step commutation tables, request and configuration structs.
// No dependencies; used by every module of the block.
`default_nettype none

package bgmd_pkg;

    localparam int DUTY_W  = 8;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 8;
    localparam int VOLT_W  = 18;
    localparam int FULL_W  = 15;
    localparam int TORQ_W  = 9;

    localparam logic [DUTY_W-1:0] DUTY_CLAMP      = 8'd100;
    localparam logic [DUTY_W-1:0] DUTY_OPEN_LIMIT = 8'd20;
    localparam logic [POS_W:0]    TORQUE_MARGIN   = 9'd5;
    localparam logic [TORQ_W-1:0] SPRING_TORQUE   = 9'(30 << 4);

    // Division of (level << 10) by 100 as level * RECIP_100 >> RECIP_SHIFT.
    // The reciprocal is exact for every level below 2^15.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    typedef enum logic [2:0] {
        MODE_DISABLE = 3'd0,
        MODE_BRAKE   = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_CLOSE   = 3'd3,
        MODE_STEADY  = 3'd4,
        MODE_INVALID = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        LVL_ZERO = 2'd0,
        LVL_HALF = 2'd1,
        LVL_FULL = 2'd2
    } lvl_t;

    typedef enum logic [2:0] {
        CFG_SUPPLY_SCALE     = 3'd0,
        CFG_UPPER_OPEN_LIMIT = 3'd1,
        CFG_LOW_DUTY_LIMIT   = 3'd2,
        CFG_VALVE_STOP_LIMIT = 3'd3,
        CFG_MOTOR_STOP_LIMIT = 3'd4
    } cfg_idx_t;

    // Gate patterns {a_hi, a_lo, b_hi, b_lo, c_hi, c_lo}, indexed by rotor
    // phase. Phases zero and seven hold an unused pattern and are masked.
    localparam logic [5:0] TBL_CLOSE [8] = '{
        6'b000000, 6'b100100, 6'b100001, 6'b001001,
        6'b011000, 6'b010010, 6'b000110, 6'b000000};
    localparam logic [5:0] TBL_OPEN [8] = '{
        6'b000000, 6'b011000, 6'b010010, 6'b000110,
        6'b100100, 6'b100001, 6'b001001, 6'b000000};
    localparam logic [5:0] TBL_STEADY [8] = '{
        6'b000000, 6'b001001, 6'b011000, 6'b010010,
        6'b000110, 6'b100100, 6'b100001, 6'b000000};

    // Per-phase drive levels {a, b, c}, indexed by rotor phase.
    localparam lvl_t LVL_MAP_OPEN [8][3] = '{
        '{LVL_ZERO, LVL_ZERO, LVL_ZERO},
        '{LVL_FULL, LVL_ZERO, LVL_HALF},
        '{LVL_FULL, LVL_HALF, LVL_ZERO},
        '{LVL_HALF, LVL_FULL, LVL_ZERO},
        '{LVL_ZERO, LVL_FULL, LVL_HALF},
        '{LVL_ZERO, LVL_HALF, LVL_FULL},
        '{LVL_HALF, LVL_ZERO, LVL_FULL},
        '{LVL_ZERO, LVL_ZERO, LVL_ZERO}};
    localparam lvl_t LVL_MAP_CLOSE [8][3] = '{
        '{LVL_ZERO, LVL_ZERO, LVL_ZERO},
        '{LVL_ZERO, LVL_FULL, LVL_HALF},
        '{LVL_ZERO, LVL_HALF, LVL_FULL},
        '{LVL_HALF, LVL_ZERO, LVL_FULL},
        '{LVL_FULL, LVL_ZERO, LVL_HALF},
        '{LVL_FULL, LVL_HALF, LVL_ZERO},
        '{LVL_HALF, LVL_FULL, LVL_ZERO},
        '{LVL_ZERO, LVL_ZERO, LVL_ZERO}};

    typedef struct packed {
        logic              gate_high_a;
        logic              gate_high_b;
        logic              gate_high_c;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [2:0]        rotor_phase;
        logic [POS_W-1:0]  position;
    } sample_t;

    typedef struct packed {
        logic [CFG_W-1:0] supply_scale;
        logic [CFG_W-1:0] upper_open_limit;
        logic [CFG_W-1:0] low_duty_limit;
        logic [CFG_W-1:0] valve_stop_limit;
        logic [CFG_W-1:0] motor_stop_limit;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic              update;
        logic              torque_on;
        lvl_t              lvl_a;
        lvl_t              lvl_b;
        lvl_t              lvl_c;
        logic [FULL_W-1:0] full;
    } decode_t;

endpackage

`default_nettype wire

>>> sv/bgmd_decode.sv
// Drive mode decoder: matches the gate levels against the six-step tables,
// decides validity and the per-phase levels, and forms the full-scale level.
// Depends on bgmd_pkg.
`default_nettype none

module bgmd_decode
(
    input  wire bgmd_pkg::sample_t sample,
    input  wire bgmd_pkg::cfg_t    cfg,
    output bgmd_pkg::decode_t      dec
);

    logic                          la;
    logic                          lb;
    logic                          lc;
    logic [5:0]                    sig;
    logic                          phase_ok;
    logic                          open_hit;
    logic                          close_hit;
    logic                          steady_hit;
    logic [bgmd_pkg::DUTY_W-1:0]   dmax_ab;
    logic [bgmd_pkg::DUTY_W-1:0]   dmax;
    logic [6:0]                    dclamp;
    logic                          open_zero;
    bgmd_pkg::mode_t               mode;

    assign la  = |sample.duty_a;
    assign lb  = |sample.duty_b;
    assign lc  = |sample.duty_c;
    assign sig = {sample.gate_high_a, la, sample.gate_high_b, lb, sample.gate_high_c, lc};

    assign phase_ok   = (sample.rotor_phase != 3'd0) && (sample.rotor_phase != 3'd7);
    assign open_hit   = phase_ok && (sig == bgmd_pkg::TBL_OPEN[sample.rotor_phase]);
    assign close_hit  = phase_ok && (sig == bgmd_pkg::TBL_CLOSE[sample.rotor_phase]);
    assign steady_hit = phase_ok && (sig == bgmd_pkg::TBL_STEADY[sample.rotor_phase]);

    assign dmax_ab = (sample.duty_a > sample.duty_b) ? sample.duty_a : sample.duty_b;
    assign dmax    = (sample.duty_c > dmax_ab) ? sample.duty_c : dmax_ab;
    assign dclamp  = (dmax > bgmd_pkg::DUTY_CLAMP) ? bgmd_pkg::DUTY_CLAMP[6:0] : dmax[6:0];

    assign open_zero = (dmax <= cfg.low_duty_limit) && (sample.position >= cfg.valve_stop_limit);

    always_comb
    begin
        priority if (sample.gate_high_a && sample.gate_high_b && sample.gate_high_c)
        begin
            mode = bgmd_pkg::MODE_INVALID;
        end
        else if (!(sample.gate_high_a || sample.gate_high_b || sample.gate_high_c))
        begin
            mode = (!(la || lb || lc) || (la && lb && lc)) ? bgmd_pkg::MODE_DISABLE
                                                           : bgmd_pkg::MODE_INVALID;
        end
        else if (sample.gate_high_a ^ sample.gate_high_b ^ sample.gate_high_c)
        begin
            priority if (open_hit)
            begin
                mode = bgmd_pkg::MODE_OPEN;
            end
            else if (close_hit)
            begin
                mode = bgmd_pkg::MODE_CLOSE;
            end
            else if (steady_hit)
            begin
                mode = bgmd_pkg::MODE_STEADY;
            end
            else
            begin
                mode = bgmd_pkg::MODE_INVALID;
            end
        end
        else
        begin
            mode = bgmd_pkg::MODE_INVALID;
        end
    end

    always_comb
    begin
        dec.mode      = mode;
        dec.full      = bgmd_pkg::FULL_W'(cfg.supply_scale * dclamp);
        dec.torque_on = (mode == bgmd_pkg::MODE_DISABLE) &&
                        ({1'b0, sample.position} >
                         ({1'b0, cfg.valve_stop_limit} + bgmd_pkg::TORQUE_MARGIN));
        dec.update    = 1'b0;
        dec.lvl_a     = bgmd_pkg::LVL_ZERO;
        dec.lvl_b     = bgmd_pkg::LVL_ZERO;
        dec.lvl_c     = bgmd_pkg::LVL_ZERO;
        unique case (mode)
            bgmd_pkg::MODE_OPEN:
            begin
                dec.update = !((sample.position >= cfg.upper_open_limit) &&
                               (dmax >= bgmd_pkg::DUTY_OPEN_LIMIT));
                if (!open_zero)
                begin
                    dec.lvl_a = bgmd_pkg::LVL_MAP_OPEN[sample.rotor_phase][0];
                    dec.lvl_b = bgmd_pkg::LVL_MAP_OPEN[sample.rotor_phase][1];
                    dec.lvl_c = bgmd_pkg::LVL_MAP_OPEN[sample.rotor_phase][2];
                end
            end
            bgmd_pkg::MODE_CLOSE:
            begin
                dec.update = sample.position > cfg.motor_stop_limit;
                dec.lvl_a  = bgmd_pkg::LVL_MAP_CLOSE[sample.rotor_phase][0];
                dec.lvl_b  = bgmd_pkg::LVL_MAP_CLOSE[sample.rotor_phase][1];
                dec.lvl_c  = bgmd_pkg::LVL_MAP_CLOSE[sample.rotor_phase][2];
            end
            bgmd_pkg::MODE_DISABLE, bgmd_pkg::MODE_BRAKE:
            begin
                dec.update = sample.position > cfg.motor_stop_limit;
            end
            default:
            begin
                dec.update = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/bgmd_volt_scale.sv
// Phase voltage scaling: (level << 10) / 100 for the full and half levels
// by a constant reciprocal, then a per-phase selection. Depends on bgmd_pkg.
`default_nettype none

module bgmd_volt_scale
(
    input  wire [bgmd_pkg::FULL_W-1:0] full,
    input  wire bgmd_pkg::lvl_t        lvl_a,
    input  wire bgmd_pkg::lvl_t        lvl_b,
    input  wire bgmd_pkg::lvl_t        lvl_c,
    output logic [bgmd_pkg::VOLT_W-1:0] volt_a,
    output logic [bgmd_pkg::VOLT_W-1:0] volt_b,
    output logic [bgmd_pkg::VOLT_W-1:0] volt_c
);

    localparam int PROD_W = bgmd_pkg::FULL_W + bgmd_pkg::RECIP_W;

    logic [bgmd_pkg::FULL_W-1:0] half;
    logic [PROD_W-1:0]           prod_full;
    logic [PROD_W-1:0]           prod_half;
    logic [bgmd_pkg::VOLT_W-1:0] v_full;
    logic [bgmd_pkg::VOLT_W-1:0] v_half;

    assign half      = full >> 1;
    assign prod_full = PROD_W'(full) * PROD_W'(bgmd_pkg::RECIP_100);
    assign prod_half = PROD_W'(half) * PROD_W'(bgmd_pkg::RECIP_100);
    assign v_full    = prod_full[bgmd_pkg::RECIP_SHIFT +: bgmd_pkg::VOLT_W];
    assign v_half    = prod_half[bgmd_pkg::RECIP_SHIFT +: bgmd_pkg::VOLT_W];

    function automatic logic [bgmd_pkg::VOLT_W-1:0] pick
    (
        input bgmd_pkg::lvl_t              code,
        input logic [bgmd_pkg::VOLT_W-1:0] vf,
        input logic [bgmd_pkg::VOLT_W-1:0] vh
    );
        logic [bgmd_pkg::VOLT_W-1:0] v;
        unique case (code)
            bgmd_pkg::LVL_FULL: v = vf;
            bgmd_pkg::LVL_HALF: v = vh;
            default:            v = '0;
        endcase
        return v;
    endfunction

    assign volt_a = pick(lvl_a, v_full, v_half);
    assign volt_b = pick(lvl_b, v_full, v_half);
    assign volt_c = pick(lvl_c, v_full, v_half);

endmodule

`default_nettype wire

>>> sv/bldc_gate_mode_decoder_core.sv
// Top level of the BLDC gate mode decoder: configuration registers, a
// three-register pipeline and the held phase voltages.
// Depends on bgmd_pkg, bgmd_decode and bgmd_volt_scale.
//
// One request is accepted in every cycle while the output side keeps taking
// results; each request yields one result, passing an input register, a
// decode register (mode, validity, levels and the supply-times-duty
// product) and the result register. The phase voltages of the result
// register are the held voltages themselves: they change only when a valid
// drive reaches the output, and otherwise repeat the last values.
// Configuration writes are expected only while no request is in flight.
`default_nettype none

module bldc_gate_mode_decoder_core
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        cfg_we,
    input  wire [2:0]  cfg_index,
    input  wire [7:0]  cfg_data,

    input  wire        in_valid,
    output logic       in_stall,
    input  wire        gate_high_a,
    input  wire        gate_high_b,
    input  wire        gate_high_c,
    input  wire [7:0]  duty_a,
    input  wire [7:0]  duty_b,
    input  wire [7:0]  duty_c,
    input  wire [2:0]  rotor_phase,
    input  wire [7:0]  position,

    output logic       out_valid,
    input  wire        out_stall,
    output logic [2:0] drive_mode,
    output logic       drive_valid,
    output logic [17:0] volt_a,
    output logic [17:0] volt_b,
    output logic [17:0] volt_c,
    output logic [8:0] spring_torque
);

    bgmd_pkg::cfg_t    cfg_reg;
    bgmd_pkg::cfg_t    cfg_next;

    logic              s1_valid_reg;
    bgmd_pkg::sample_t s1_sample_reg;
    logic              s2_valid_reg;
    bgmd_pkg::decode_t s2_dec_reg;
    bgmd_pkg::decode_t dec;

    logic              out_valid_reg;
    bgmd_pkg::mode_t   mode_reg;
    logic              drive_valid_reg;
    logic              torque_on_reg;
    logic [17:0]       held_a_reg;
    logic [17:0]       held_b_reg;
    logic [17:0]       held_c_reg;
    logic [17:0]       held_a_next;
    logic [17:0]       held_b_next;
    logic [17:0]       held_c_next;
    logic [17:0]       scaled_a;
    logic [17:0]       scaled_b;
    logic [17:0]       scaled_c;

    logic              in_take;
    logic              adv_s2;
    logic              adv_out;

    assign adv_out  = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign adv_s2   = s1_valid_reg && (!s2_valid_reg || adv_out);
    assign in_stall = s1_valid_reg && !adv_s2;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bgmd_pkg::CFG_SUPPLY_SCALE:     cfg_next.supply_scale     = cfg_data;
                bgmd_pkg::CFG_UPPER_OPEN_LIMIT: cfg_next.upper_open_limit = cfg_data;
                bgmd_pkg::CFG_LOW_DUTY_LIMIT:   cfg_next.low_duty_limit   = cfg_data;
                bgmd_pkg::CFG_VALVE_STOP_LIMIT: cfg_next.valve_stop_limit = cfg_data;
                bgmd_pkg::CFG_MOTOR_STOP_LIMIT: cfg_next.motor_stop_limit = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply_scale     <= 8'd12;
            cfg_reg.upper_open_limit <= 8'd100;
            cfg_reg.low_duty_limit   <= 8'd10;
            cfg_reg.valve_stop_limit <= 8'd95;
            cfg_reg.motor_stop_limit <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bgmd_decode u_decode
    (
        .sample (s1_sample_reg),
        .cfg    (cfg_reg),
        .dec    (dec)
    );

    bgmd_volt_scale u_volt_scale
    (
        .full   (s2_dec_reg.full),
        .lvl_a  (s2_dec_reg.lvl_a),
        .lvl_b  (s2_dec_reg.lvl_b),
        .lvl_c  (s2_dec_reg.lvl_c),
        .volt_a (scaled_a),
        .volt_b (scaled_b),
        .volt_c (scaled_c)
    );

    always_comb
    begin
        held_a_next = held_a_reg;
        held_b_next = held_b_reg;
        held_c_next = held_c_reg;
        if (adv_out && s2_dec_reg.update)
        begin
            held_a_next = scaled_a;
            held_b_next = scaled_b;
            held_c_next = scaled_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            held_c_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv_s2)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (adv_out)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (adv_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            held_a_reg <= held_a_next;
            held_b_reg <= held_b_next;
            held_c_reg <= held_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg.gate_high_a <= gate_high_a;
            s1_sample_reg.gate_high_b <= gate_high_b;
            s1_sample_reg.gate_high_c <= gate_high_c;
            s1_sample_reg.duty_a      <= duty_a;
            s1_sample_reg.duty_b      <= duty_b;
            s1_sample_reg.duty_c      <= duty_c;
            s1_sample_reg.rotor_phase <= rotor_phase;
            s1_sample_reg.position    <= position;
        end
        if (adv_s2)
        begin
            s2_dec_reg <= dec;
        end
        if (adv_out)
        begin
            mode_reg        <= s2_dec_reg.mode;
            drive_valid_reg <= s2_dec_reg.update;
            torque_on_reg   <= s2_dec_reg.torque_on;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_mode    = mode_reg;
    assign drive_valid   = drive_valid_reg;
    assign volt_a        = held_a_reg;
    assign volt_b        = held_b_reg;
    assign volt_c        = held_c_reg;
    assign spring_torque = torque_on_reg ? bgmd_pkg::SPRING_TORQUE : '0;

    // Steady and invalid drive never recompute the voltages.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (drive_mode == bgmd_pkg::MODE_STEADY ||
                      drive_mode == bgmd_pkg::MODE_INVALID) |-> !drive_valid)
        else $error("steady or invalid drive reported as valid");

    // A valid disable result drives all phases to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_valid && drive_mode == bgmd_pkg::MODE_DISABLE |->
            volt_a == '0 && volt_b == '0 && volt_c == '0)
        else $error("disable drive left a nonzero phase voltage");

    // Spring torque only appears with a disable result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spring_torque != '0 |-> drive_mode == bgmd_pkg::MODE_DISABLE)
        else $error("spring torque outside disable mode");

    // Held voltages change only when a result moves into the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(volt_a) || !$stable(volt_b) || !$stable(volt_c) |->
            $past(adv_out) && out_valid && drive_valid)
        else $error("held phase voltages changed without a valid result");

endmodule

`default_nettype wire

>>> test/bgmd_checker.sv
// Result checker for the BLDC gate mode decoder testbench: mirrors the
// configuration registers, predicts every accepted request and compares results.
// Depends on bgmd_pkg for the sample type, the drive modes and register indexes.
module bgmd_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [7:0]  cfg_data,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire         gate_high_a,
    input  wire         gate_high_b,
    input  wire         gate_high_c,
    input  wire  [7:0]  duty_a,
    input  wire  [7:0]  duty_b,
    input  wire  [7:0]  duty_c,
    input  wire  [2:0]  rotor_phase,
    input  wire  [7:0]  position,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire  [2:0]  drive_mode,
    input  wire         drive_valid,
    input  wire  [17:0] volt_a,
    input  wire  [17:0] volt_b,
    input  wire  [17:0] volt_c,
    input  wire  [8:0]  spring_torque,
    output int          mismatch_count,
    output int          awaited_results
);

    localparam int DUTY_CEIL       = 100;
    localparam int OPEN_DUTY_FLOOR = 20;
    localparam int STOP_MARGIN     = 5;
    localparam logic [8:0] TORQUE_ON = 9'd480;

    // Gate patterns {a_hi, a_lo, b_hi, b_lo, c_hi, c_lo} for rotor phases one to six.
    localparam logic [1:6][5:0] OPEN_ROWS =
        {6'b011000, 6'b010010, 6'b000110, 6'b100100, 6'b100001, 6'b001001};
    localparam logic [1:6][5:0] CLOSE_ROWS =
        {6'b100100, 6'b100001, 6'b001001, 6'b011000, 6'b010010, 6'b000110};
    localparam logic [1:6][5:0] STEADY_ROWS =
        {6'b001001, 6'b011000, 6'b010010, 6'b000110, 6'b100100, 6'b100001};

    // Drive level codes {a, b, c}, two bits per phase.
    localparam logic [1:6][5:0] OPEN_LEVELS =
        {6'b100001, 6'b100100, 6'b011000, 6'b001001, 6'b000110, 6'b010010};
    localparam logic [1:6][5:0] CLOSE_LEVELS =
        {6'b001001, 6'b000110, 6'b010010, 6'b100001, 6'b100100, 6'b011000};

    typedef struct packed {
        bgmd_pkg::mode_t mode;
        logic            valid;
        logic [17:0]     volt_a;
        logic [17:0]     volt_b;
        logic [17:0]     volt_c;
        logic [8:0]      torque;
    } drive_result_t;

    logic [7:0]        supply_scale;
    logic [7:0]        upper_open_limit;
    logic [7:0]        low_duty_limit;
    logic [7:0]        valve_stop_limit;
    logic [7:0]        motor_stop_limit;
    logic [17:0]       held [3];
    bgmd_pkg::sample_t seen_sample;
    drive_result_t     seen_result;
    drive_result_t     want;
    drive_result_t     expected_drives [$];

    assign seen_sample = {gate_high_a, gate_high_b, gate_high_c, duty_a, duty_b, duty_c,
                          rotor_phase, position};
    assign seen_result = {drive_mode, drive_valid, volt_a, volt_b, volt_c, spring_torque};

    function automatic void load_levels(input logic [5:0] codes, input logic [7:0] peak);
        int             full;
        int             level;
        int             k;
        bgmd_pkg::lvl_t code;
        full = int'(supply_scale) * ((peak > DUTY_CEIL) ? DUTY_CEIL : int'(peak));
        for (k = 0; k < 3; k++)
        begin
            code = bgmd_pkg::lvl_t'(codes[5 - 2 * k -: 2]);
            level = (code == bgmd_pkg::LVL_FULL) ? full :
                    ((code == bgmd_pkg::LVL_HALF) ? (full >> 1) : 0);
            held[k] = 18'((level << 10) / 100);
        end
    endfunction

    function automatic drive_result_t decode_drive(input bgmd_pkg::sample_t s);
        logic [2:0]    highs;
        logic [2:0]    lows;
        logic [5:0]    gates;
        logic [7:0]    peak;
        logic          on_row;
        drive_result_t r;
        highs = {s.gate_high_a, s.gate_high_b, s.gate_high_c};
        lows = {s.duty_a != 8'd0, s.duty_b != 8'd0, s.duty_c != 8'd0};
        gates = {highs[2], lows[2], highs[1], lows[1], highs[0], lows[0]};
        peak = s.duty_a;
        if (s.duty_b > peak)
            peak = s.duty_b;
        if (s.duty_c > peak)
            peak = s.duty_c;
        on_row = (s.rotor_phase >= 3'd1) && (s.rotor_phase <= 3'd6);

        r.mode = bgmd_pkg::MODE_INVALID;
        if (highs == 3'b000)
        begin
            if (lows == 3'b000 || lows == 3'b111)
                r.mode = bgmd_pkg::MODE_DISABLE;
        end
        else if (on_row && (highs == 3'b100 || highs == 3'b010 || highs == 3'b001))
        begin
            if (gates == OPEN_ROWS[s.rotor_phase])
                r.mode = bgmd_pkg::MODE_OPEN;
            else if (gates == CLOSE_ROWS[s.rotor_phase])
                r.mode = bgmd_pkg::MODE_CLOSE;
            else if (gates == STEADY_ROWS[s.rotor_phase])
                r.mode = bgmd_pkg::MODE_STEADY;
        end

        r.valid = 1'b1;
        case (r.mode)
            bgmd_pkg::MODE_OPEN:
            begin
                if (s.position >= upper_open_limit && peak >= OPEN_DUTY_FLOOR)
                    r.valid = 1'b0;
                else
                begin
                    load_levels(OPEN_LEVELS[s.rotor_phase], peak);
                    if (peak <= low_duty_limit && s.position >= valve_stop_limit)
                        load_levels({3{bgmd_pkg::LVL_ZERO}}, peak);
                end
            end
            bgmd_pkg::MODE_CLOSE, bgmd_pkg::MODE_DISABLE:
            begin
                if (s.position <= motor_stop_limit)
                    r.valid = 1'b0;
                else if (r.mode == bgmd_pkg::MODE_CLOSE)
                    load_levels(CLOSE_LEVELS[s.rotor_phase], peak);
                else
                    load_levels({3{bgmd_pkg::LVL_ZERO}}, peak);
            end
            default:
                r.valid = 1'b0;
        endcase

        r.torque = (r.mode == bgmd_pkg::MODE_DISABLE &&
                    int'(s.position) > int'(valve_stop_limit) + STOP_MARGIN) ? TORQUE_ON : 9'd0;
        r.volt_a = held[0];
        r.volt_b = held[1];
        r.volt_c = held[2];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("bgmd_checker: %0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_scale     = 8'd12;
            upper_open_limit = 8'd100;
            low_duty_limit   = 8'd10;
            valve_stop_limit = 8'd95;
            motor_stop_limit = 8'd0;
            held[0] = '0;
            held[1] = '0;
            held[2] = '0;
            expected_drives.delete();
            awaited_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bgmd_pkg::CFG_SUPPLY_SCALE:     supply_scale = cfg_data;
                    bgmd_pkg::CFG_UPPER_OPEN_LIMIT: upper_open_limit = cfg_data;
                    bgmd_pkg::CFG_LOW_DUTY_LIMIT:   low_duty_limit = cfg_data;
                    bgmd_pkg::CFG_VALVE_STOP_LIMIT: valve_stop_limit = cfg_data;
                    bgmd_pkg::CFG_MOTOR_STOP_LIMIT: motor_stop_limit = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_drives.push_back(decode_drive(seen_sample));
            if (out_valid && !out_stall)
            begin
                if (expected_drives.size() == 0)
                    flag_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_drives.pop_front();
                    if (seen_result.mode !== want.mode)
                        flag_mismatch($sformatf("drive_mode %0d, expected %0d",
                                                seen_result.mode, want.mode));
                    if (seen_result.valid !== want.valid)
                        flag_mismatch($sformatf("drive_valid %0b, expected %0b",
                                                seen_result.valid, want.valid));
                    if (seen_result.volt_a !== want.volt_a)
                        flag_mismatch($sformatf("volt_a %0d, expected %0d",
                                                seen_result.volt_a, want.volt_a));
                    if (seen_result.volt_b !== want.volt_b)
                        flag_mismatch($sformatf("volt_b %0d, expected %0d",
                                                seen_result.volt_b, want.volt_b));
                    if (seen_result.volt_c !== want.volt_c)
                        flag_mismatch($sformatf("volt_c %0d, expected %0d",
                                                seen_result.volt_c, want.volt_c));
                    if (seen_result.torque !== want.torque)
                        flag_mismatch($sformatf("spring_torque %0d, expected %0d",
                                                seen_result.torque, want.torque));
                end
            end
            awaited_results <= expected_drives.size();
        end
    end

endmodule

>>> test/testbench.sv
// Top of the BLDC gate mode decoder testbench: clock, reset, register
// settings and gate sample requests with random gaps and output stalls.
// Depends on bgmd_pkg, bldc_gate_mode_decoder_core and bgmd_checker.
module testbench;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        gate_high_a = 1'b0;
    logic        gate_high_b = 1'b0;
    logic        gate_high_c = 1'b0;
    logic [7:0]  duty_a = '0;
    logic [7:0]  duty_b = '0;
    logic [7:0]  duty_c = '0;
    logic [2:0]  rotor_phase = '0;
    logic [7:0]  position = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  drive_mode;
    logic        drive_valid;
    logic [17:0] volt_a;
    logic [17:0] volt_b;
    logic [17:0] volt_c;
    logic [8:0]  spring_torque;
    logic        calm = 1'b0;
    int          mismatch_count;
    int          awaited_results;

    bldc_gate_mode_decoder_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .gate_high_a(gate_high_a), .gate_high_b(gate_high_b), .gate_high_c(gate_high_c),
        .duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c),
        .rotor_phase(rotor_phase), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_mode(drive_mode), .drive_valid(drive_valid),
        .volt_a(volt_a), .volt_b(volt_b), .volt_c(volt_c),
        .spring_torque(spring_torque)
    );

    bgmd_checker u_check
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .gate_high_a(gate_high_a), .gate_high_b(gate_high_b), .gate_high_c(gate_high_c),
        .duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c),
        .rotor_phase(rotor_phase), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_mode(drive_mode), .drive_valid(drive_valid),
        .volt_a(volt_a), .volt_b(volt_b), .volt_c(volt_c),
        .spring_torque(spring_torque),
        .mismatch_count(mismatch_count), .awaited_results(awaited_results)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 36);

    initial
    begin
        #200000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [7:0] pick_duty();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(1, 30));
            1:       return 8'($urandom_range(90, 110));
            2:       return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 10));
            1:       return 8'($urandom_range(85, 110));
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(240, 255));
        endcase
    endfunction

    // Gates are {a_hi, a_lo, b_hi, b_lo, c_hi, c_lo}; an active low side gets the duty.
    function automatic bgmd_pkg::sample_t gate_sample(input logic [5:0] g,
                                                      input logic [2:0] phase,
                                                      input logic [7:0] duty,
                                                      input logic [7:0] pos);
        bgmd_pkg::sample_t s;
        s.gate_high_a = g[5];
        s.duty_a      = g[4] ? duty : 8'd0;
        s.gate_high_b = g[3];
        s.duty_b      = g[2] ? duty : 8'd0;
        s.gate_high_c = g[1];
        s.duty_c      = g[0] ? duty : 8'd0;
        s.rotor_phase = phase;
        s.position    = pos;
        return s;
    endfunction

    function automatic bgmd_pkg::sample_t random_sample();
        bgmd_pkg::sample_t s;
        int                pick;
        logic [2:0]        phase;
        logic [5:0]        g;
        logic [63:0]       noise;
        pick = $urandom_range(0, 99);
        phase = 3'($urandom_range(1, 6));
        if (pick >= 72)
        begin
            noise = {$urandom, $urandom};
            s = noise[$bits(bgmd_pkg::sample_t)-1:0];
            return s;
        end
        if (pick < 25)
            g = bgmd_pkg::TBL_OPEN[phase];
        else if (pick < 45)
            g = bgmd_pkg::TBL_CLOSE[phase];
        else if (pick < 60)
            g = bgmd_pkg::TBL_STEADY[phase];
        else
            g = $urandom_range(0, 1) ? 6'b010101 : 6'b000000;
        s = gate_sample(g, phase, pick_duty(), pick_position());
        if (s.duty_b != 8'd0)
            s.duty_b = pick_duty();
        if (s.duty_c != 8'd0)
            s.duty_c = pick_duty();
        if ($urandom_range(0, 9) == 0)
            s.rotor_phase = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        return s;
    endfunction

    task automatic send_request(input bgmd_pkg::sample_t s);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        gate_high_a <= s.gate_high_a;
        gate_high_b <= s.gate_high_b;
        gate_high_c <= s.gate_high_c;
        duty_a      <= s.duty_a;
        duty_b      <= s.duty_b;
        duty_c      <= s.duty_c;
        rotor_phase <= s.rotor_phase;
        position    <= s.position;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic put_reg(input bgmd_pkg::cfg_idx_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] scale, input logic [7:0] upper,
                                input logic [7:0] low_duty, input logic [7:0] valve_stop,
                                input logic [7:0] motor_stop);
        put_reg(bgmd_pkg::CFG_SUPPLY_SCALE, scale);
        put_reg(bgmd_pkg::CFG_UPPER_OPEN_LIMIT, upper);
        put_reg(bgmd_pkg::CFG_LOW_DUTY_LIMIT, low_duty);
        put_reg(bgmd_pkg::CFG_VALVE_STOP_LIMIT, valve_stop);
        put_reg(bgmd_pkg::CFG_MOTOR_STOP_LIMIT, motor_stop);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int round;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(gate_sample(6'b000000, 3'd1, 8'd0, 8'd50));
        for (ph = 1; ph <= 6; ph++)
            send_request(gate_sample(bgmd_pkg::TBL_OPEN[ph], 3'(ph), 8'(ph * 40), 8'd50));
        for (ph = 1; ph <= 6; ph++)
            send_request(gate_sample(bgmd_pkg::TBL_CLOSE[ph], 3'(ph), 8'(ph * 15 + 1),
                                     8'(ph * 40)));
        send_request(gate_sample(bgmd_pkg::TBL_CLOSE[2], 3'd2, 8'd77, 8'd0));
        send_request(gate_sample(bgmd_pkg::TBL_STEADY[3], 3'd3, 8'd60, 8'd40));
        send_request(gate_sample(6'b000000, 3'd0, 8'd0, 8'd255));
        send_request(gate_sample(6'b010101, 3'd5, 8'd255, 8'd101));
        send_request(gate_sample(6'b010101, 3'd4, 8'd3, 8'd0));
        send_request(gate_sample(6'b010000, 3'd1, 8'd9, 8'd50));
        send_request(gate_sample(6'b101010, 3'd2, 8'd0, 8'd50));
        send_request(gate_sample(6'b111000, 3'd4, 8'd33, 8'd50));
        send_request(gate_sample(bgmd_pkg::TBL_OPEN[1], 3'd0, 8'd50, 8'd50));
        send_request(gate_sample(bgmd_pkg::TBL_OPEN[4], 3'd7, 8'd50, 8'd50));
        send_request(gate_sample(bgmd_pkg::TBL_OPEN[2], 3'd2, 8'd20, 8'd100));
        send_request(gate_sample(bgmd_pkg::TBL_OPEN[2], 3'd2, 8'd19, 8'd100));
        send_request(gate_sample(bgmd_pkg::TBL_OPEN[5], 3'd5, 8'd10, 8'd95));

        for (round = 0; round < 8; round++)
        begin
            settle();
            case (round)
                0: apply_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                1: apply_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: apply_config(8'd255, 8'd0, 8'd255, 8'd0, 8'd254);
                3: apply_config(8'd200, 8'd60, 8'd30, 8'd90, 8'd20);
                4: apply_config(8'd12, 8'd100, 8'd10, 8'd95, 8'd0);
                5: apply_config(8'd255, 8'd120, 8'd40, 8'd80, 8'd1);
                default: apply_config(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom));
            endcase
            // One round runs with every request and result taken back to back.
            calm <= (round == 4);
            @(posedge clk);
            for (n = 0; n < 50; n++)
                send_request(random_sample());
        end
        calm <= 1'b0;
        settle();

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> bldc_gate_mode_decoder_core.f
sv/bgmd_pkg.sv
sv/bgmd_decode.sv
sv/bgmd_volt_scale.sv
sv/bldc_gate_mode_decoder_core.sv
test/bgmd_checker.sv
test/testbench.sv
